[rtl/mhpq_pkg.sv]
// Shared types and codes of the min-heap priority queue unit.
// No dependencies; every other file of the block refers to it by scoped names.
package mhpq_pkg;

   localparam int unsigned VALUE_W  = 32;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned OCC_W    = 4;

   // Operation kinds on the request side.
   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_REMOVE = 1'b1;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   // Operation broadcast to every cell of the row.
   typedef struct packed {
      logic                      insert;
      logic                      remove;
      logic signed [VALUE_W-1:0] value;
   } op_type;

endpackage

[rtl/mhpq_cell.sv]
// One slot of the sorted cell row of the min-heap priority queue unit.
// Depends on mhpq_pkg for the broadcast operation type.
module mhpq_cell #(
   parameter int unsigned IDX   = 0,
   parameter int unsigned CNT_W = 4
) (
   input  logic                                clock,
   input  mhpq_pkg::op_type                    op,
   input  logic [CNT_W-1:0]                    count,
   input  logic                                left_ahead,
   input  logic signed [mhpq_pkg::VALUE_W-1:0] left_value,
   input  logic signed [mhpq_pkg::VALUE_W-1:0] right_value,
   output logic                                ahead,
   output logic signed [mhpq_pkg::VALUE_W-1:0] value
);

   logic signed [mhpq_pkg::VALUE_W-1:0] value_ff;
   logic signed [mhpq_pkg::VALUE_W-1:0] value_in;
   logic                                occupied;

   assign occupied = (count > CNT_W'(IDX));
   // New value goes in front of this slot (ties go behind the stored copy).
   assign ahead    = !occupied || (op.value < value_ff);
   assign value    = value_ff;

   always_comb begin
      value_in = value_ff;
      if (op.insert && ahead) begin
         // Shift right: take the left neighbor, or the new value at the boundary.
         value_in = left_ahead ? left_value : op.value;
      end else if (op.remove) begin
         value_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

[rtl/min_heap_priority_queue_unit.sv]
// Top level of the min-heap priority queue unit: request/response streams and cell row.
// Depends on mhpq_pkg and mhpq_cell.

// Bounded min-priority queue of signed 32-bit values. Each request word is an
// insert (req_tuser = 0) or a remove-minimum (req_tuser = 1); each produces one
// response word carrying the removed minimum (zero for inserts and empty
// removals), a status (0 done, 1 insert dropped because full, 2 remove on empty
// queue) and the occupancy after the operation, low 4 bits. The queue is kept
// as a sorted row of QUEUE_DEPTH cells: an insert shifts the larger entries one
// cell right and drops the new value into the gap, a remove shifts the row one
// cell left. The unit takes one word per clock; the single response register
// decouples the two sides and stalls input only while a response waits
// unaccepted. Equal values leave in arrival order. Cells past the fill count
// hold undefined data and are never read.
module min_heap_priority_queue_unit #(
   parameter int unsigned QUEUE_DEPTH = 15
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic        req_tuser,   // [0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // [31:0] min_value, [33:32] status, [37:34] occupancy
);

   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [CNT_W-1:0]                    count_ff;
   logic [CNT_W-1:0]                    count_in;
   logic                                rsp_valid_ff;
   logic                                rsp_valid_in;
   logic [39:0]                         rsp_data_ff;
   logic [39:0]                         rsp_data_in;

   logic                                accept;
   logic                                full;
   logic                                empty;
   mhpq_pkg::op_type                    op;
   logic [mhpq_pkg::STATUS_W-1:0]       status;
   logic signed [mhpq_pkg::VALUE_W-1:0] min_value;

   logic                                cell_ahead [QUEUE_DEPTH];
   logic signed [mhpq_pkg::VALUE_W-1:0] cell_value [QUEUE_DEPTH];

   // Take a new word whenever the response register is free or draining.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty      = (count_ff == '0);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Broadcast the operation; drop inserts when full and removes when empty.
   always_comb begin
      op.value  = $signed(req_tdata);
      op.insert = accept && (req_tuser == mhpq_pkg::KIND_INSERT) && !full;
      op.remove = accept && (req_tuser == mhpq_pkg::KIND_REMOVE) && !empty;
   end

   // Cell row: the minimum always sits in cell 0.
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      localparam int unsigned LEFT  = (i == 0) ? 0 : i - 1;
      localparam int unsigned RIGHT = (i == QUEUE_DEPTH - 1) ? i : i + 1;

      mhpq_cell #(
         .IDX   (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock       (clock),
         .op          (op),
         .count       (count_ff),
         .left_ahead  ((i == 0) ? 1'b0 : cell_ahead[LEFT]),
         .left_value  (cell_value[LEFT]),
         .right_value (cell_value[RIGHT]),
         .ahead       (cell_ahead[i]),
         .value       (cell_value[i])
      );
   end

   // Work out status, count and response word.
   always_comb begin
      status    = mhpq_pkg::STATUS_DONE;
      min_value = '0;
      count_in  = count_ff;
      if (req_tuser == mhpq_pkg::KIND_INSERT) begin
         if (full) begin
            status = mhpq_pkg::STATUS_FULL;
         end else begin
            count_in = count_ff + CNT_W'(1);
         end
      end else begin
         if (empty) begin
            status = mhpq_pkg::STATUS_EMPTY;
         end else begin
            min_value = cell_value[0];
            count_in  = count_ff - CNT_W'(1);
         end
      end
      rsp_data_in = 40'({mhpq_pkg::OCC_W'(count_in), status, min_value});
      if (!accept) begin
         count_in = count_ff;
      end
   end

   // Hold the response until taken; load a new one on each accepted word.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule
